/* rtl/sbt_pkg.sv */
// ----------------------------------------------------------------------------
// sbt_pkg: shared types, codes and keyword automaton for the script tokenizer
// Token kinds, one-hot lexer modes, ASCII codes and the keyword prefix
// automaton that runs while an identifier is collected.
// ----------------------------------------------------------------------------
`default_nettype none

package sbt_pkg;

    // default width of the line, column and length counters
    localparam int POSITION_BITS = 16;

    // token kinds as they leave on tuser
    typedef enum logic [4:0] {
        KIND_COLON  = 5'd0,
        KIND_SEMI   = 5'd1,
        KIND_LPAREN = 5'd2,
        KIND_RPAREN = 5'd3,
        KIND_LCURLY = 5'd4,
        KIND_RCURLY = 5'd5,
        KIND_PLUS   = 5'd6,
        KIND_STAR   = 5'd7,
        KIND_ASSIGN = 5'd8,
        KIND_EQUAL  = 5'd9,
        KIND_INT    = 5'd10,
        KIND_FLOAT  = 5'd11,
        KIND_RETURN = 5'd12,
        KIND_IF     = 5'd13,
        KIND_I32    = 5'd14,
        KIND_F32    = 5'd15,
        KIND_IDENT  = 5'd16,
        KIND_END    = 5'd17,
        KIND_ERROR  = 5'd18
    } t_kind;

    // lexer modes, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_EQ    = 5'b00010,
        MODE_NUM   = 5'b00100,
        MODE_IDENT = 5'b01000,
        MODE_ERR   = 5'b10000
    } t_mode;

    // one result beat before it is split onto tuser and tdata
    typedef struct packed {
        t_kind       kind;
        logic [15:0] len;
        logic [15:0] col;
        logic [15:0] line;
    } t_result;

    // ascii codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_RCURLY = 8'h7D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_2      = 8'h32;
    localparam logic [7:0] CH_3      = 8'h33;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // keyword prefix states
    localparam logic [3:0] KW_NONE   = 4'd0;
    localparam logic [3:0] KW_R      = 4'd1;
    localparam logic [3:0] KW_RE     = 4'd2;
    localparam logic [3:0] KW_RET    = 4'd3;
    localparam logic [3:0] KW_RETU   = 4'd4;
    localparam logic [3:0] KW_RETUR  = 4'd5;
    localparam logic [3:0] KW_RETURN = 4'd6;
    localparam logic [3:0] KW_I      = 4'd7;
    localparam logic [3:0] KW_IF     = 4'd8;
    localparam logic [3:0] KW_I3     = 4'd9;
    localparam logic [3:0] KW_I32    = 4'd10;
    localparam logic [3:0] KW_F      = 4'd11;
    localparam logic [3:0] KW_F3     = 4'd12;
    localparam logic [3:0] KW_F32    = 4'd13;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
    endfunction

    // first letter of an identifier
    function automatic logic [3:0] kw_start(input logic [7:0] c);
        logic [3:0] k;
        k = KW_NONE;
        if (c == CH_R)      k = KW_R;
        else if (c == CH_I) k = KW_I;
        else if (c == CH_F) k = KW_F;
        return k;
    endfunction

    // advance the prefix automaton by one character
    function automatic logic [3:0] kw_next(input logic [3:0] k, input logic [7:0] c);
        logic [3:0] nk;
        nk = KW_NONE;
        unique case (k)
            KW_R:     if (c == CH_E) nk = KW_RE;
            KW_RE:    if (c == CH_T) nk = KW_RET;
            KW_RET:   if (c == CH_U) nk = KW_RETU;
            KW_RETU:  if (c == CH_R) nk = KW_RETUR;
            KW_RETUR: if (c == CH_N) nk = KW_RETURN;
            KW_I: begin
                if (c == CH_F)      nk = KW_IF;
                else if (c == CH_3) nk = KW_I3;
            end
            KW_I3:    if (c == CH_2) nk = KW_I32;
            KW_F:     if (c == CH_3) nk = KW_F3;
            KW_F3:    if (c == CH_2) nk = KW_F32;
            default:  nk = KW_NONE;
        endcase
        return nk;
    endfunction

    // kind of a finished identifier
    function automatic t_kind ident_kind(input logic [3:0] k);
        t_kind kd;
        unique case (k)
            KW_RETURN: kd = KIND_RETURN;
            KW_IF:     kd = KIND_IF;
            KW_I32:    kd = KIND_I32;
            KW_F32:    kd = KIND_F32;
            default:   kd = KIND_IDENT;
        endcase
        return kd;
    endfunction

endpackage

`default_nettype wire

/* rtl/script_byte_tokenizer.sv */
// ----------------------------------------------------------------------------
// script_byte_tokenizer: streaming lexer for a small script language
// Takes one script byte per beat and emits tokens with kind, position and
// lexeme length.
// ----------------------------------------------------------------------------
// Usage:
//   slave side: one script byte per beat on i_s_tdata, i_s_tlast marks the
//   last byte of a script. Master side: one token per beat, kind on
//   o_m_tuser, line/column/length on o_m_tdata, o_m_tlast on the last token
//   caused by an input byte.
//   A byte yields zero to three tokens: a pending token that the byte ends,
//   the byte's own token (punctuation, '==', float, error), and on the last
//   byte a flushed pending token plus the end token.
//   The first token of a byte is on the master side in the cycle after the
//   byte's beat is accepted.
//   Throughput: one byte per cycle while each byte yields at most one token
//   and the receiver is ready; a byte that yields more tokens holds the slave
//   side while the three-entry result queue drains, one token per ready cycle.
//   The next byte is taken in the same cycle that the last queued token of
//   the previous byte leaves; the lexer state waits while tokens are queued.
//   Receiver stall: queued tokens hold steady; tready drops until the queue
//   is down to its leaving token.
//   Reset: queue empty, lexer idle, line/column/length counters at zero.
//   After the last byte all lexer state returns to reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module script_byte_tokenizer #(
    parameter int POSITION_BITS = sbt_pkg::POSITION_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] char_byte
    input  wire logic        i_s_tlast,   // final_byte
    // master side
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata,   // [15:0] token_line, [31:16] token_column,
                                          // [47:32] lexeme_length
    output logic [4:0]       o_m_tuser,   // [4:0] token_kind
    output logic             o_m_tlast    // run_end
);

    localparam int P  = POSITION_BITS;
    localparam int XW = (P > 16) ? P : 16;

    // saturating increment of a position counter
    function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
        return (v == {P{1'b1}}) ? v : v + P'(1);
    endfunction

    // clip a counter to the 16-bit output field
    function automatic logic [15:0] clip16(input logic [P-1:0] v);
        logic [XW-1:0] x;
        x = XW'(v);
        return (x > XW'(16'hFFFF)) ? 16'hFFFF : x[15:0];
    endfunction

    // lexer state
    sbt_pkg::t_mode r_mode, n_mode;
    logic [P-1:0]   r_line, n_line;
    logic [P-1:0]   r_col,  n_col;
    logic [P-1:0]   r_len,  n_len;
    logic [3:0]     r_kw,   n_kw;

    // result queue
    sbt_pkg::t_result r_slot [3];
    logic [2:0]       r_last;
    logic [1:0]       r_cnt;

    logic in_acc, out_acc;
    logic [7:0] c;

    // candidate results of the current byte
    logic                v0, v1, v2;
    sbt_pkg::t_kind      k0, k1;
    logic [P-1:0]        len0, len1;
    logic                done;
    sbt_pkg::t_result    e0, e1, e2;
    sbt_pkg::t_result    q0, q1;
    logic [1:0]          n_res;

    assign c       = i_s_tdata;
    assign in_acc  = i_s_tvalid && o_s_tready;
    assign out_acc = o_m_tvalid && i_m_tready;

    // take a byte when the queue is empty or its last token is leaving
    assign o_s_tready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_m_tready);

    // lexer next state and candidate tokens
    always_comb begin
        n_mode = r_mode;
        n_line = r_line;
        n_col  = r_col;
        n_len  = r_len;
        n_kw   = r_kw;
        done   = 1'b0;
        v0     = 1'b0;
        v1     = 1'b0;
        v2     = 1'b0;
        k0     = sbt_pkg::KIND_ASSIGN;
        k1     = sbt_pkg::KIND_ERROR;
        len0   = '0;
        len1   = '0;

        // continue or end the pending token
        unique case (r_mode)
            sbt_pkg::MODE_ERR: done = 1'b1;
            sbt_pkg::MODE_EQ: begin
                if (c == sbt_pkg::CH_EQ) begin
                    n_col  = sat_inc(r_col);
                    v1     = 1'b1;
                    k1     = sbt_pkg::KIND_EQUAL;
                    len1   = P'(2);
                    n_mode = sbt_pkg::MODE_IDLE;
                    done   = 1'b1;
                end else begin
                    v0     = 1'b1;
                    k0     = sbt_pkg::KIND_ASSIGN;
                    len0   = P'(1);
                    n_mode = sbt_pkg::MODE_IDLE;
                end
            end
            sbt_pkg::MODE_NUM: begin
                if (sbt_pkg::is_digit(c) || (c == sbt_pkg::CH_DOT)) begin
                    n_col = sat_inc(r_col);
                    n_len = sat_inc(r_len);
                    done  = 1'b1;
                end else if (c == sbt_pkg::CH_F) begin
                    n_col  = sat_inc(r_col);
                    v1     = 1'b1;
                    k1     = sbt_pkg::KIND_FLOAT;
                    len1   = r_len;
                    n_mode = sbt_pkg::MODE_IDLE;
                    done   = 1'b1;
                end else begin
                    v0     = 1'b1;
                    k0     = sbt_pkg::KIND_INT;
                    len0   = r_len;
                    n_mode = sbt_pkg::MODE_IDLE;
                end
            end
            sbt_pkg::MODE_IDENT: begin
                if (sbt_pkg::is_alpha(c) || sbt_pkg::is_digit(c)) begin
                    n_col = sat_inc(r_col);
                    n_len = sat_inc(r_len);
                    n_kw  = sbt_pkg::kw_next(r_kw, c);
                    done  = 1'b1;
                end else begin
                    v0     = 1'b1;
                    k0     = sbt_pkg::ident_kind(r_kw);
                    len0   = r_len;
                    n_mode = sbt_pkg::MODE_IDLE;
                end
            end
            sbt_pkg::MODE_IDLE: n_mode = sbt_pkg::MODE_IDLE;
            default:            n_mode = sbt_pkg::MODE_IDLE;
        endcase

        // the byte starts something new
        if (!done) begin
            n_col = sat_inc(r_col);
            unique case (c)
                sbt_pkg::CH_SPACE: ;
                sbt_pkg::CH_LF: begin
                    n_line = sat_inc(r_line);
                    n_col  = '0;
                end
                sbt_pkg::CH_COLON:  begin v1 = 1'b1; k1 = sbt_pkg::KIND_COLON;  len1 = P'(1); end
                sbt_pkg::CH_SEMI:   begin v1 = 1'b1; k1 = sbt_pkg::KIND_SEMI;   len1 = P'(1); end
                sbt_pkg::CH_LPAREN: begin v1 = 1'b1; k1 = sbt_pkg::KIND_LPAREN; len1 = P'(1); end
                sbt_pkg::CH_RPAREN: begin v1 = 1'b1; k1 = sbt_pkg::KIND_RPAREN; len1 = P'(1); end
                sbt_pkg::CH_LCURLY: begin v1 = 1'b1; k1 = sbt_pkg::KIND_LCURLY; len1 = P'(1); end
                sbt_pkg::CH_RCURLY: begin v1 = 1'b1; k1 = sbt_pkg::KIND_RCURLY; len1 = P'(1); end
                sbt_pkg::CH_PLUS:   begin v1 = 1'b1; k1 = sbt_pkg::KIND_PLUS;   len1 = P'(1); end
                sbt_pkg::CH_STAR:   begin v1 = 1'b1; k1 = sbt_pkg::KIND_STAR;   len1 = P'(1); end
                sbt_pkg::CH_EQ:     n_mode = sbt_pkg::MODE_EQ;
                default: begin
                    if (sbt_pkg::is_digit(c)) begin
                        n_mode = sbt_pkg::MODE_NUM;
                        n_len  = P'(1);
                    end else if (sbt_pkg::is_alpha(c)) begin
                        n_mode = sbt_pkg::MODE_IDENT;
                        n_len  = P'(1);
                        n_kw   = sbt_pkg::kw_start(c);
                    end else begin
                        v1     = 1'b1;
                        k1     = sbt_pkg::KIND_ERROR;
                        len1   = '0;
                        n_mode = sbt_pkg::MODE_ERR;
                    end
                end
            endcase
        end

        // last byte: flush what is pending, then the end token
        e2.kind = sbt_pkg::KIND_END;
        e2.line = clip16(n_line);
        e2.col  = clip16(n_col);
        e2.len  = 16'd0;
        if (i_s_tlast) begin
            v2 = 1'b1;
            if (n_mode == sbt_pkg::MODE_EQ) begin
                v1   = 1'b1;
                k1   = sbt_pkg::KIND_ASSIGN;
                len1 = P'(1);
            end else if (n_mode == sbt_pkg::MODE_NUM) begin
                v1   = 1'b1;
                k1   = sbt_pkg::KIND_INT;
                len1 = n_len;
            end else if (n_mode == sbt_pkg::MODE_IDENT) begin
                v1   = 1'b1;
                k1   = sbt_pkg::ident_kind(n_kw);
                len1 = n_len;
            end
        end

        e0.kind = k0;
        e0.line = clip16(r_line);
        e0.col  = clip16(r_col);
        e0.len  = clip16(len0);
        e1.kind = k1;
        e1.line = clip16(n_line);
        e1.col  = clip16(n_col);
        e1.len  = clip16(len1);

        // a finished script returns the lexer to reset values
        if (i_s_tlast) begin
            n_mode = sbt_pkg::MODE_IDLE;
            n_line = '0;
            n_col  = '0;
            n_len  = '0;
            n_kw   = sbt_pkg::KW_NONE;
        end
    end

    // pack the candidate tokens to the front of the queue
    always_comb begin
        q0    = v0 ? e0 : (v1 ? e1 : e2);
        q1    = (v0 && v1) ? e1 : e2;
        n_res = 2'({1'b0, v0}) + 2'({1'b0, v1}) + 2'({1'b0, v2});
    end

    // lexer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sbt_pkg::MODE_IDLE;
            r_line <= '0;
            r_col  <= '0;
            r_len  <= '0;
            r_kw   <= sbt_pkg::KW_NONE;
        end else if (in_acc) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_col  <= n_col;
            r_len  <= n_len;
            r_kw   <= n_kw;
        end
    end

    // result queue count and run-end marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_last <= 3'b000;
        end else if (in_acc) begin
            r_cnt     <= n_res;
            r_last[0] <= (n_res == 2'd1);
            r_last[1] <= (n_res == 2'd2);
            r_last[2] <= (n_res == 2'd3);
        end else if (out_acc) begin
            r_cnt  <= r_cnt - 2'd1;
            r_last <= {1'b0, r_last[2:1]};
        end
    end

    // result queue payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_slot[0] <= q0;
            r_slot[1] <= q1;
            r_slot[2] <= e2;
        end else if (out_acc) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

    // master side straight from the queue head
    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tuser  = r_slot[0].kind;
    assign o_m_tdata  = {r_slot[0].len, r_slot[0].col, r_slot[0].line};
    assign o_m_tlast  = r_last[0];

endmodule

`default_nettype wire

/* rtl/sbt_checker.sv */
// ----------------------------------------------------------------------------
// sbt_checker: port-level checks for the script tokenizer
// Watches the stream ports of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [47:0] i_out_data,
    input wire logic [4:0]  i_out_user,
    input wire logic        i_out_last
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_data) && $stable(i_out_user) && $stable(i_out_last))
        else $error("result beat changed while stalled");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // an empty result side always takes a byte
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("slave side not ready with empty queue");

    // the end token closes the run of its byte
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_user == sbt_pkg::KIND_END) |-> i_out_last)
        else $error("end token without run end");

    // end and error tokens carry no lexeme
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_out_user == sbt_pkg::KIND_END) ||
                        (i_out_user == sbt_pkg::KIND_ERROR)) |-> (i_out_data[47:32] == 16'd0))
        else $error("end or error token with nonzero length");

endmodule

bind script_byte_tokenizer sbt_checker u_sbt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_s_tready),
    .i_out_valid (o_m_tvalid),
    .i_out_ready (i_m_tready),
    .i_out_data  (o_m_tdata),
    .i_out_user  (o_m_tuser),
    .i_out_last  (o_m_tlast)
);

`default_nettype wire

/* test/script_byte_tokenizer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_byte_tokenizer_tb: self-checking bench for the streaming script lexer
// Feeds whole scripts byte by byte, predicts every token with an independent
// lexer model and checks each token beat field by field. Covers punctuation,
// '=' against '==', int and float literals, keywords and near misses, errors
// and skipped bytes, under random gaps and stalls.
// ----------------------------------------------------------------------------

module script_byte_tokenizer_tb;
    import sbt_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_BYTES  = 80;
    localparam int DRAIN_CYCLES  = 8;
    localparam int NUM_KINDS     = 19;

    // one expected token beat
    typedef struct {
        t_kind       kind;
        logic [15:0] line;
        logic [15:0] col;
        logic [15:0] len;
        logic        last;
    } token_t;

    // token predictor and in-order checker
    class token_scoreboard;
        token_t      pending_tokens[$];
        t_mode       mode;
        logic [15:0] line_no;
        logic [15:0] col_no;
        logic [15:0] lex_len;
        string       word;
        int          failures;
        int          bytes_lexed;
        int          bytes_skipped;
        int          tokens_seen;
        bit          kind_seen[NUM_KINDS];

        function new();
            restart();
        endfunction

        function void restart();
            mode    = MODE_IDLE;
            line_no = '0;
            col_no  = '0;
            lex_len = '0;
            word    = "";
        endfunction

        function logic [15:0] bump(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function bit digit(logic [7:0] c);
            return c >= CH_0 && c <= CH_9;
        endfunction

        function bit letter(logic [7:0] c);
            return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
        endfunction

        // keywords are compared on the text itself, only the first chars are kept
        function t_kind word_kind();
            if (word == "return") return KIND_RETURN;
            if (word == "if")     return KIND_IF;
            if (word == "i32")    return KIND_I32;
            if (word == "f32")    return KIND_F32;
            return KIND_IDENT;
        endfunction

        function void emit(t_kind k, logic [15:0] len);
            token_t t;
            t.kind = k;
            t.line = line_no;
            t.col  = col_no;
            t.len  = len;
            t.last = 1'b0;
            pending_tokens = {pending_tokens, t};
        endfunction

        // close the token that waits for a terminating byte
        function void flush();
            case (mode)
                MODE_EQ:    emit(KIND_ASSIGN, 16'd1);
                MODE_NUM:   emit(KIND_INT, lex_len);
                MODE_IDENT: emit(word_kind(), lex_len);
                default: ;
            endcase
            if (mode != MODE_ERR) mode = MODE_IDLE;
        endfunction

        function int outstanding();
            return pending_tokens.size();
        endfunction

        // one accepted script byte
        function void lex_byte(logic [7:0] c, logic fin);
            int n_prior;
            bit taken;
            n_prior = pending_tokens.size();
            taken = 1'b0;
            if (mode == MODE_ERR) bytes_skipped++;
            else bytes_lexed++;

            // continue a pending token
            case (mode)
                MODE_ERR: taken = 1'b1;
                MODE_EQ: begin
                    if (c == CH_EQ) begin
                        col_no = bump(col_no);
                        emit(KIND_EQUAL, 16'd2);
                        mode = MODE_IDLE;
                        taken = 1'b1;
                    end else begin
                        flush();
                    end
                end
                MODE_NUM: begin
                    if (digit(c) || c == CH_DOT) begin
                        col_no = bump(col_no);
                        lex_len = bump(lex_len);
                        taken = 1'b1;
                    end else if (c == CH_F) begin
                        // suffix is eaten, counted in the column but not in the length
                        col_no = bump(col_no);
                        emit(KIND_FLOAT, lex_len);
                        mode = MODE_IDLE;
                        taken = 1'b1;
                    end else begin
                        flush();
                    end
                end
                MODE_IDENT: begin
                    if (letter(c) || digit(c)) begin
                        col_no = bump(col_no);
                        lex_len = bump(lex_len);
                        if (word.len() < 8) word = $sformatf("%s%c", word, c);
                        taken = 1'b1;
                    end else begin
                        flush();
                    end
                end
                default: ;
            endcase

            // byte starts something of its own
            if (!taken) begin
                col_no = bump(col_no);
                case (c)
                    CH_SPACE: ;
                    CH_LF: begin
                        line_no = bump(line_no);
                        col_no = '0;
                    end
                    CH_COLON:  emit(KIND_COLON, 16'd1);
                    CH_SEMI:   emit(KIND_SEMI, 16'd1);
                    CH_LPAREN: emit(KIND_LPAREN, 16'd1);
                    CH_RPAREN: emit(KIND_RPAREN, 16'd1);
                    CH_LCURLY: emit(KIND_LCURLY, 16'd1);
                    CH_RCURLY: emit(KIND_RCURLY, 16'd1);
                    CH_PLUS:   emit(KIND_PLUS, 16'd1);
                    CH_STAR:   emit(KIND_STAR, 16'd1);
                    CH_EQ:     mode = MODE_EQ;
                    default: begin
                        if (digit(c)) begin
                            mode = MODE_NUM;
                            lex_len = 16'd1;
                        end else if (letter(c)) begin
                            mode = MODE_IDENT;
                            lex_len = 16'd1;
                            word = $sformatf("%c", c);
                        end else begin
                            emit(KIND_ERROR, 16'd0);
                            mode = MODE_ERR;
                        end
                    end
                endcase
            end

            // end of script closes everything and starts over
            if (fin) begin
                flush();
                emit(KIND_END, 16'd0);
                restart();
            end

            if (pending_tokens.size() > n_prior)
                pending_tokens[pending_tokens.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                failures++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        // one accepted token beat
        function void check_token(logic [4:0] kind, logic [15:0] line, logic [15:0] col,
                                  logic [15:0] len, logic last);
            token_t want;
            tokens_seen++;
            if (kind < NUM_KINDS) kind_seen[kind] = 1'b1;
            if (pending_tokens.size() == 0) begin
                failures++;
                $display("%0t: token with none expected, got kind %0d line %0d col %0d len %0d",
                         $time, kind, line, col, len);
                return;
            end
            want = pending_tokens.pop_front();
            compare_field("kind", 16'(want.kind), 16'(kind));
            compare_field("line", want.line, line);
            compare_field("column", want.col, col);
            compare_field("length", want.len, len);
            compare_field("tlast", 16'(want.last), 16'(last));
        endfunction
    endclass

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [47:0] m_tdata;
    wire logic [4:0]  m_tuser;
    wire logic        m_tlast;

    token_scoreboard sb = new();
    logic [7:0] script_bytes[$];
    int cycles       = 0;
    int scripts_sent = 0;
    int stall_left   = 0;
    int ready_calm   = 0;
    int send_calm    = 0;

    script_byte_tokenizer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d tokens still expected",
                     cycles, sb.outstanding());
            $display("Mismatches found");
            $finish;
        end
    end

    // idle length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(2, 1);
        if (r < 95) return $urandom_range(8, 3);
        return $urandom_range(40, 20);
    endfunction

    function automatic int sender_gap();
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        if ($urandom_range(99) < 3) send_calm = $urandom_range(30, 10);
        if ($urandom_range(99) < 60) return 0;
        return idle_len();
    endfunction

    // receiver stalls, with calm stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (ready_calm > 0) ready_calm--;
            else if ($urandom_range(99) < 4) ready_calm = $urandom_range(60, 20);
            else if ($urandom_range(99) < 25) stall_left = idle_len();
        end
    end

    // both handshakes are sampled mid-cycle, where all signals are settled
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) sb.lex_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_token(m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tlast);
        end
    end

    // one byte beat, returns at the edge that accepts it
    task automatic send_byte(input logic [7:0] b, input logic fin, input bit paced);
        int gap;
        gap = paced ? sender_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do @(negedge i_clk); while (!s_tready);
        @(posedge i_clk);
    endtask

    task automatic send_script(input bit paced);
        for (int i = 0; i < script_bytes.size(); i++)
            send_byte(script_bytes[i], i == script_bytes.size() - 1, paced);
        script_bytes.delete();
        scripts_sent++;
    endtask

    // sender holds off until every token has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() > 0);
    endtask

    // append one byte to the script being built
    function automatic void add_byte(logic [7:0] b);
        script_bytes = {script_bytes, b};
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic void add_number();
        int n;
        n = $urandom_range(5, 1);
        add_byte(CH_0 + 8'($urandom_range(9)));
        for (int i = 1; i < n; i++)
            add_byte(($urandom_range(99) < 20) ? CH_DOT : CH_0 + 8'($urandom_range(9)));
        if ($urandom_range(99) < 35) add_byte(CH_F);
    endfunction

    function automatic void add_identifier();
        string keywords[4] = '{"return", "if", "i32", "f32"};
        string near_miss[10] = '{"ret", "i3", "f3", "returns", "iff", "i32x", "f", "r",
                                 "F32", "f32a"};
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 40) begin
            add_text(keywords[$urandom_range(3)]);
        end else if (r < 65) begin
            add_text(near_miss[$urandom_range(9)]);
        end else begin
            n = $urandom_range(6, 1);
            for (int i = 0; i < n; i++) begin
                if (i > 0 && $urandom_range(99) < 25)
                    add_byte(CH_0 + 8'($urandom_range(9)));
                else if ($urandom_range(1))
                    add_byte(CH_LA + 8'($urandom_range(25)));
                else
                    add_byte(CH_UA + 8'($urandom_range(25)));
            end
        end
    endfunction

    // one lexeme, then maybe a separator
    function automatic void add_random_token();
        logic [7:0] punct[8] = '{CH_COLON, CH_SEMI, CH_LPAREN, CH_RPAREN,
                                 CH_LCURLY, CH_RCURLY, CH_PLUS, CH_STAR};
        int r;
        r = $urandom_range(99);
        if (r < 20) add_byte(punct[$urandom_range(7)]);
        else if (r < 30) begin
            add_byte(CH_EQ);
            if ($urandom_range(1)) add_byte(CH_EQ);
        end
        else if (r < 55) add_number();
        else if (r < 85) add_identifier();
        else if (r < 93) add_byte(CH_LF);
        else if (r < 95) add_byte(CH_DOT);
        else add_byte(8'($urandom_range(255)));
        r = $urandom_range(99);
        if (r < 50) add_byte(CH_SPACE);
        else if (r < 55) add_byte(CH_LF);
    endfunction

    initial begin
        int kinds_hit;
        int lexed_mark;
        int n_tokens;
        bit paused;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: punctuation, equal, assign, float with suffix, line feed
        add_text(":;(){}+*==\n=1.2f");
        send_script(1'b1);
        // letter and digit edges, keyword, int flushed by the last byte
        add_text("Zaz9 if 0");
        send_script(1'b1);
        // identifier, error and end from one byte
        add_text("x\t");
        send_script(1'b1);
        // leading dot
        add_text(".");
        send_script(1'b1);
        // carriage return error, later byte skipped
        add_text("\r;");
        send_script(1'b1);
        // high bytes and a zero byte
        add_byte(8'hFF);
        send_script(1'b1);
        add_byte(8'h80);
        add_byte(8'h00);
        send_script(1'b1);
        wait_drained();

        // random scripts of mostly well-formed tokens
        lexed_mark = sb.bytes_lexed;
        paused = 1'b0;
        while (sb.bytes_lexed < lexed_mark + RANDOM_BYTES) begin
            n_tokens = $urandom_range(8, 1);
            repeat (n_tokens) add_random_token();
            send_script(1'b1);
            if (!paused && sb.bytes_lexed >= lexed_mark + RANDOM_BYTES / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end

        // let the last tokens out
        s_tvalid <= 1'b0;
        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        kinds_hit = 0;
        for (int k = 0; k < NUM_KINDS; k++) kinds_hit += sb.kind_seen[k];
        $display("%0d scripts, %0d bytes lexed, %0d bytes skipped after errors",
                 scripts_sent, sb.bytes_lexed, sb.bytes_skipped);
        $display("%0d tokens checked, %0d of %0d kinds seen",
                 sb.tokens_seen, kinds_hit, NUM_KINDS);
        if (sb.failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
rtl/sbt_pkg.sv
rtl/script_byte_tokenizer.sv
rtl/sbt_checker.sv
test/script_byte_tokenizer_tb.sv
